// ===== hw/rtl/hus_pkg.sv =====
// shared types and constants for the url splitter
// phase and kind codes, the job record passed from front to back, prefix patterns
// no dependencies
package hus_pkg;

    // parse phase, one-hot
    typedef enum logic [4:0] {
        PH_FIRST  = 5'b00001,
        PH_PREFIX = 5'b00010,
        PH_HOST   = 5'b00100,
        PH_PORT   = 5'b01000,
        PH_PATH   = 5'b10000
    } t_phase;

    // kind of a result beat
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_HOST = 2'd1,
        KIND_PATH = 2'd2
    } t_kind;

    localparam int JOB_SLOTS    = 8;
    localparam int RESULT_SLOTS = 10;
    localparam int SLOT_SLASH   = 8;
    localparam int SLOT_SILENT  = 9;
    localparam int HTTPS_LEN    = 8;
    localparam int HTTP_LEN     = 7;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [7:0]  CH_COLON     = 8'h3A;
    localparam logic [7:0]  CH_SLASH     = 8'h2F;
    localparam logic [15:0] PORT_DEFAULT = 16'd80;
    localparam logic [15:0] PORT_MAX     = 16'hFFFF;

    // prefix patterns, entry 0 is the first character
    localparam logic [7:0][7:0] PAT_HTTPS = {
        8'h2F, 8'h2F, 8'h3A, 8'h73, 8'h70, 8'h74, 8'h74, 8'h68
    };
    localparam logic [7:0][7:0] PAT_HTTP = {
        8'h00, 8'h2F, 8'h2F, 8'h3A, 8'h70, 8'h74, 8'h74, 8'h68
    };

    // work for the back end: up to eight byte slots, a slash slot and a silent slot
    typedef struct packed {
        logic [JOB_SLOTS-1:0][7:0]  slot_byte;
        t_kind                      slot0_kind;
        logic [RESULT_SLOTS-1:0]    pend;
        logic                       last;
        logic                       https;
        logic [15:0]                port;
    } t_job;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

endpackage

// ===== hw/rtl/hus_front.sv =====
// front end: accepts url bytes, tracks prefix, host, port and path phases
// and builds one job record per byte; depends on hus_pkg
module hus_front import hus_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  logic        i_full,
    output logic        o_push,
    output t_job        o_job
);

    t_phase             r_phase, n_phase;
    logic [7:0][7:0]    r_store, n_store;
    logic [2:0]         r_cnt, n_cnt;
    logic               r_s_ok, n_s_ok;
    logic               r_p_ok, n_p_ok;
    logic               r_https, n_https;
    logic [15:0]        r_port, n_port;
    logic               r_open, n_open;
    logic               r_conn, n_conn;

    logic               acc;
    logic               do_prefix;
    logic [2:0]         cnt_base;
    logic               s_base, p_base;
    logic               s_hit, p_hit;
    t_kind              k0;
    logic [19:0]        port_mul;
    logic [7:0][7:0]    rb;
    logic [7:0]         rv;
    logic [7:0]         host_mask;
    logic               seen, pf, bad;
    logic [15:0]        pdig;
    logic               slash;

    assign o_ready = !i_full;
    assign acc     = i_valid && !i_full;
    assign o_push  = acc && (|o_job.pend);

    // port digit step with saturation
    assign port_mul = ({4'b0, r_port} << 3) + ({4'b0, r_port} << 1) + {16'b0, i_byte[3:0]};

    // held bytes plus this byte, as they would replay
    always_comb begin
        for (int i = 0; i < JOB_SLOTS; i++) begin
            rb[i] = (3'(i) == cnt_base) ? i_byte : r_store[i];
            rv[i] = (3'(i) <= cnt_base);
        end
    end

    // replay scan: host bytes before the first colon, port from the byte after it
    always_comb begin
        seen      = 1'b0;
        pf        = 1'b0;
        bad       = 1'b0;
        pdig      = 16'd0;
        host_mask = '0;
        for (int i = 0; i < JOB_SLOTS; i++) begin
            if (rv[i]) begin
                if (seen) begin
                    if (!is_digit(rb[i])) begin
                        bad = 1'b1;
                    end else if (pf) begin
                        pdig = {12'b0, rb[i][3:0]};
                    end
                end else if (rb[i] != CH_COLON) begin
                    host_mask[i] = 1'b1;
                end
                pf = !seen && (rb[i] == CH_COLON);
                if (rb[i] == CH_COLON) begin
                    seen = 1'b1;
                end
            end else begin
                pf = 1'b0;
            end
        end
    end

    // next state and job record
    always_comb begin
        n_phase   = r_phase;
        n_store   = r_store;
        n_cnt     = r_cnt;
        n_s_ok    = r_s_ok;
        n_p_ok    = r_p_ok;
        n_https   = r_https;
        n_port    = r_port;
        n_open    = r_open;
        n_conn    = r_conn;
        do_prefix = 1'b0;
        cnt_base  = r_cnt;
        s_base    = r_s_ok;
        p_base    = r_p_ok;
        s_hit     = 1'b0;
        p_hit     = 1'b0;
        k0        = KIND_NONE;
        o_job     = '0;

        // single byte through the current phase
        unique case (r_phase)
            PH_FIRST: begin
                if (i_byte == CH_SLASH) begin
                    n_phase = PH_PATH;
                    k0      = KIND_PATH;
                end else begin
                    do_prefix = 1'b1;
                    cnt_base  = 3'd0;
                    s_base    = 1'b1;
                    p_base    = 1'b1;
                end
            end
            PH_PREFIX: begin
                do_prefix = 1'b1;
            end
            PH_HOST: begin
                if (i_byte == CH_COLON) begin
                    n_phase = PH_PORT;
                    n_port  = 16'd0;
                    n_open  = 1'b1;
                end else if (i_byte == CH_SLASH && !r_conn) begin
                    n_phase = PH_PATH;
                    k0      = KIND_PATH;
                end else begin
                    k0 = KIND_HOST;
                end
            end
            PH_PORT: begin
                if (i_byte == CH_SLASH && !r_conn) begin
                    n_phase = PH_PATH;
                    k0      = KIND_PATH;
                end else if (r_open && is_digit(i_byte)) begin
                    n_port = (port_mul > {4'b0, PORT_MAX}) ? PORT_MAX : port_mul[15:0];
                end else begin
                    n_open = 1'b0;
                end
            end
            PH_PATH: begin
                k0 = KIND_PATH;
            end
            default: begin
                n_phase = PH_FIRST;
            end
        endcase

        o_job.slot_byte[0] = i_byte;
        o_job.slot0_kind   = k0;
        o_job.pend[0]      = (k0 != KIND_NONE);

        // prefix matching, completion or replay in connect form
        if (do_prefix) begin
            n_store[cnt_base] = i_byte;
            s_hit = s_base && (i_byte == PAT_HTTPS[cnt_base]);
            p_hit = p_base && (cnt_base != 3'(HTTP_LEN)) && (i_byte == PAT_HTTP[cnt_base]);
            if (s_hit && cnt_base == 3'(HTTPS_LEN - 1)) begin
                n_https = 1'b1;
                n_cnt   = 3'd0;
                n_phase = PH_HOST;
            end else if (p_hit && cnt_base == 3'(HTTP_LEN - 1)) begin
                n_https = 1'b0;
                n_cnt   = 3'd0;
                n_phase = PH_HOST;
            end else if ((s_hit || p_hit) && !i_last) begin
                n_cnt   = cnt_base + 3'd1;
                n_s_ok  = s_hit;
                n_p_ok  = p_hit;
                n_phase = PH_PREFIX;
            end else begin
                n_conn            = 1'b1;
                n_https           = 1'b0;
                n_cnt             = 3'd0;
                n_phase           = seen ? PH_PORT : PH_HOST;
                n_port            = seen ? pdig : PORT_DEFAULT;
                n_open            = seen && !bad;
                o_job.slot_byte   = rb;
                o_job.slot0_kind  = KIND_HOST;
                o_job.pend[JOB_SLOTS-1:0] = host_mask;
            end
        end

        // end of url: supplied slash, or a silent beat carrying last
        slash                      = i_last && !n_conn && (n_phase != PH_PATH);
        o_job.pend[SLOT_SLASH]     = slash;
        o_job.pend[SLOT_SILENT]    = i_last && !(|o_job.pend[SLOT_SLASH:0]);
        o_job.last                 = i_last;
        o_job.https                = n_https;
        o_job.port                 = n_port;
    end

    // parse state, back to reset values after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (acc && i_last)) begin
            r_phase <= PH_FIRST;
            r_cnt   <= 3'd0;
            r_s_ok  <= 1'b0;
            r_p_ok  <= 1'b0;
            r_https <= 1'b0;
            r_port  <= PORT_DEFAULT;
            r_open  <= 1'b0;
            r_conn  <= 1'b0;
        end else if (acc) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_s_ok  <= n_s_ok;
            r_p_ok  <= n_p_ok;
            r_https <= n_https;
            r_port  <= n_port;
            r_open  <= n_open;
            r_conn  <= n_conn;
        end
    end

    // held prefix bytes
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_store <= n_store;
        end
    end

endmodule

// ===== hw/rtl/hus_queue.sv =====
// short job queue between front and back end
// two entries of t_job; depends on hus_pkg
module hus_queue import hus_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_pop,
    output t_job    o_job
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job               r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // occupancy
    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ===== hw/rtl/hus_back.sv =====
// back end: walks the pending slots of a job and drives one result beat per cycle
// unless i_m_tready stalls, through a registered output stage; depends on hus_pkg
module hus_back import hus_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_byte,
    output t_kind       o_m_kind,
    output logic        o_m_last,
    output logic        o_m_https,
    output logic [15:0] o_m_port
);

    t_job                       r_cur;
    logic [RESULT_SLOTS-1:0]    r_pend;
    logic                       r_out_valid;
    logic [7:0]                 r_out_byte;
    t_kind                      r_out_kind;
    logic                       r_out_last;
    logic                       r_out_https;
    logic [15:0]                r_out_port;

    logic [RESULT_SLOTS-1:0]    pick, rest;
    logic                       have, can_load, emit;
    logic [7:0]                 sel_byte;
    t_kind                      sel_kind;

    assign have     = |r_pend;
    assign pick     = r_pend & (~r_pend + RESULT_SLOTS'(1));
    assign rest     = r_pend & ~pick;
    assign can_load = !r_out_valid || i_m_tready;
    assign emit     = can_load && have;
    assign o_pop    = i_valid && (!have || (emit && (rest == '0)));

    // select the lowest pending slot
    always_comb begin
        sel_byte = 8'd0;
        sel_kind = KIND_NONE;
        for (int i = 0; i < JOB_SLOTS; i++) begin
            if (pick[i]) begin
                sel_byte = r_cur.slot_byte[i];
                sel_kind = (i == 0) ? r_cur.slot0_kind : KIND_HOST;
            end
        end
        if (pick[SLOT_SLASH]) begin
            sel_byte = CH_SLASH;
            sel_kind = KIND_PATH;
        end
    end

    // current job and pending slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (o_pop) begin
            r_pend <= i_job.pend;
        end else if (emit) begin
            r_pend <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_job;
        end
    end

    // output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte  <= sel_byte;
            r_out_kind  <= sel_kind;
            r_out_last  <= r_cur.last && (rest == '0);
            r_out_https <= r_cur.https;
            r_out_port  <= r_cur.port;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_byte   = r_out_byte;
    assign o_m_kind   = r_out_kind;
    assign o_m_last   = r_out_last;
    assign o_m_https  = r_out_https;
    assign o_m_port   = r_out_port;

endmodule

// ===== hw/rtl/http_url_splitter_unit.sv =====
// url splitter: one byte per beat in, host and path bytes with scheme and port out
// throughput: one byte per cycle in while the job queue has room, one result beat
// per cycle out while m_tready is high; a step that replays a broken prefix gives
// up to six beats, the output stage sets the pace
// reset: synchronous active-low i_rst_n clears parse state, job queue and output stage
module http_url_splitter_unit import hus_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // in_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] out_byte, [8] scheme_https, [24:9] port_number
    output logic [1:0]  m_tuser,   // [1:0] out_kind
    output logic        m_tlast    // out_last
);

    t_job           push_job, head_job;
    logic           push, full, head_valid, pop;
    logic [7:0]     out_byte;
    t_kind          out_kind;
    logic           out_https;
    logic [15:0]    out_port;

    // classify bytes
    hus_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_byte  (s_tdata),
        .i_last  (s_tlast),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    // decouple front and back
    hus_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .o_valid (head_valid),
        .i_pop   (pop),
        .o_job   (head_job)
    );

    // emit result beats
    hus_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (head_valid),
        .i_job      (head_job),
        .o_pop      (pop),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_byte   (out_byte),
        .o_m_kind   (out_kind),
        .o_m_last   (m_tlast),
        .o_m_https  (out_https),
        .o_m_port   (out_port)
    );

    assign m_tdata = {7'd0, out_port, out_https, out_byte};
    assign m_tuser = out_kind;

endmodule
